### hw/rtl/rfo_pkg.sv
package rfo_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int ELEM_BITS_DEF = 32;
    localparam int DATA_W        = 32;
    localparam int CNT_W         = 6;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CNT_W-1:0] CAP_RESET = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY  = 1'b0,
        CFG_OVERWRITE = 1'b1
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_OVERWROTE = 2'd2,
        ST_REJECTED  = 2'd3
    } status_t;

    typedef struct packed {
        logic             valid;
        logic             read_ok;
        status_t          status;
        logic [CNT_W-1:0] count;
    } rfo_res_t;

endpackage

### hw/rtl/rfo_ram.sv
module rfo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/rfo_ctrl.sv
module rfo_ctrl #(
    parameter int DEPTH = rfo_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rfo_pkg::FUNC_W-1:0]      func,
    input  logic                            cfg_we,
    input  logic [rfo_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rfo_pkg::CNT_W-1:0]       cfg_data,
    output logic                            busy,
    output logic                            mem_we,
    output logic [$clog2(DEPTH)-1:0]        mem_waddr,
    output logic                            mem_re,
    output logic [$clog2(DEPTH)-1:0]        mem_raddr,
    output rfo_pkg::rfo_res_t               res
);
    import rfo_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int CAP_MAX = (DEPTH < (2**CNT_W - 1)) ? DEPTH : (2**CNT_W - 1);
    localparam int CMP_W   = ((AW > CNT_W) ? AW : CNT_W) + 1;

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg;
    logic             ovw_reg;
    logic             busy_reg;
    rfo_res_t         res_reg, res_next;

    logic [CNT_W-1:0] cap_eff;
    logic             go;
    logic             full;
    logic             wr;
    logic [CMP_W-1:0] head_inc, tail_inc;
    logic [AW-1:0]    head_adv, tail_adv;

    assign go   = start && !busy_reg;
    assign full = count_reg >= cap_eff;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(CAP_MAX))
        begin
            cap_eff = CNT_W'(CAP_MAX);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign head_inc = CMP_W'(head_reg) + CMP_W'(1);
    assign tail_inc = CMP_W'(tail_reg) + CMP_W'(1);
    assign head_adv = (head_inc >= CMP_W'(cap_eff)) ? '0 : head_inc[AW-1:0];
    assign tail_adv = (tail_inc >= CMP_W'(cap_eff)) ? '0 : tail_inc[AW-1:0];

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        wr          = 1'b0;
        res_next    = '{valid: go, read_ok: 1'b0, status: ST_DONE, count: count_reg};
        case (func_t'(func))
            FUNC_ENQ:
            begin
                if (full)
                begin
                    if (ovw_reg)
                    begin
                        head_next       = head_adv;
                        res_next.status = ST_OVERWROTE;
                        wr              = 1'b1;
                    end
                    else
                    begin
                        res_next.status = ST_REJECTED;
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    wr         = 1'b1;
                end
                if (wr)
                begin
                    tail_next = tail_adv;
                end
            end
            FUNC_DEQ, FUNC_PEEK:
            begin
                if (count_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.read_ok = 1'b1;
                    if (func_t'(func) == FUNC_DEQ)
                    begin
                        head_next  = head_adv;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        res_next.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            ovw_reg   <= 1'b1;
            busy_reg  <= 1'b0;
            res_reg   <= '{valid: 1'b0, read_ok: 1'b0, status: ST_DONE, count: '0};
        end
        else
        begin
            busy_reg <= go;
            res_reg  <= res_next;
            if (cfg_we && cfg_idx_t'(cfg_index) == CFG_CAPACITY)
            begin
                cap_reg   <= cfg_data;
                head_reg  <= '0;
                tail_reg  <= '0;
                count_reg <= '0;
            end
            else if (go)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (cfg_we && cfg_idx_t'(cfg_index) == CFG_OVERWRITE)
            begin
                ovw_reg <= cfg_data[0];
            end
        end
    end

    assign busy      = busy_reg;
    assign mem_we    = go && wr;
    assign mem_waddr = tail_reg;
    assign mem_re    = go;
    assign mem_raddr = head_reg;
    assign res       = res_reg;

endmodule

### hw/rtl/ring_fifo_overwrite.sv
// Channel  | Handshake        | Payload
// ---------+------------------+-----------------------------
// request  | start, busy      | func, value
// result   | done             | data_out, status, fill_count
// config   | cfg_we           | cfg_index, cfg_data
//
// A request is accepted at the edge where start is high and busy low; the result is
// shown with done in the cycle after, with data_out from the registered read of the
// ring memory. busy is high in that cycle, so no request enters while a result shows.
// Reset empties the ring; capacity returns to 32 and overwrite mode is on.
// The receiver cannot stall: done lasts exactly one cycle.
module ring_fifo_overwrite #(
    parameter int DEPTH     = rfo_pkg::DEPTH_DEF,
    parameter int ELEM_BITS = rfo_pkg::ELEM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rfo_pkg::FUNC_W-1:0]    func,
    input  logic [rfo_pkg::DATA_W-1:0]    value,
    output logic                          done,
    output logic [rfo_pkg::DATA_W-1:0]    data_out,
    output logic [1:0]                    status,
    output logic [rfo_pkg::CNT_W-1:0]     fill_count,
    input  logic                          cfg_we,
    input  logic [rfo_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfo_pkg::CNT_W-1:0]     cfg_data
);
    import rfo_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [ELEM_BITS-1:0] mem_rdata;
    rfo_res_t             res;

    rfo_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .res       (res)
    );

    rfo_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (ELEM_BITS'(value)),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done       = res.valid;
    assign data_out   = res.read_ok ? DATA_W'(mem_rdata) : '0;
    assign status     = res.status;
    assign fill_count = res.count;

endmodule

### hw/rtl/rfo_checker.sv
module rfo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [rfo_pkg::DATA_W-1:0]    data_out,
    input logic [1:0]                    status,
    input logic [rfo_pkg::CNT_W-1:0]     fill_count
);
    import rfo_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
        else $error("transfer accepted without a result next cycle");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without an accepted transfer");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> fill_count == '0 && data_out == '0)
        else $error("empty result with data or nonzero count");

    a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_OVERWROTE || status == ST_REJECTED) |-> fill_count != '0)
        else $error("full result with zero count");

endmodule

bind ring_fifo_overwrite rfo_checker u_rfo_checker (.*);
